>>> rtl/jntp_pkg.sv
// Shared types, phase codes, character codes and helpers for the JSON number token parser.
package jntp_pkg;

    localparam int TextWidth   = 8;
    localparam int MagWidth    = 63;
    localparam int CountWidth  = 8;
    localparam int ExpMagWidth = 31;
    localparam int ExpWidth    = 32;
    localparam int OutDataWidth = 176;

    localparam logic [MagWidth-1:0]    MagMax = {MagWidth{1'b1}};
    localparam logic [MagWidth-1:0]    ExpMax = {{(MagWidth-ExpMagWidth){1'b0}},
                                                 {ExpMagWidth{1'b1}}};
    localparam logic [CountWidth-1:0]  CountMax = {CountWidth{1'b1}};

    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_SIGN    = 4'd1;
    localparam logic [3:0] PH_ZERO    = 4'd2;
    localparam logic [3:0] PH_WHOLE   = 4'd3;
    localparam logic [3:0] PH_DOT     = 4'd4;
    localparam logic [3:0] PH_FRAC    = 4'd5;
    localparam logic [3:0] PH_EXP     = 4'd6;
    localparam logic [3:0] PH_EXPSIGN = 4'd7;
    localparam logic [3:0] PH_EXPDIG  = 4'd8;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_E_LOW  = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic                        stop_byte_used;
        logic                        overflowed;
        logic signed [ExpWidth-1:0]  exponent_value;
        logic [CountWidth-1:0]       fraction_digits;
        logic [MagWidth-1:0]         fraction_part;
        logic [MagWidth-1:0]         whole_part;
        logic                        is_negative;
        logic                        number_ok;
    } result_t;

    typedef struct packed {
        logic                 sat;
        logic [MagWidth-1:0]  value;
    } mac_t;

    // acc * 10 + d, clamped at max
    function automatic mac_t mac_sat(input logic [MagWidth-1:0] acc,
                                     input logic [3:0] d,
                                     input logic [MagWidth-1:0] max);
        logic [MagWidth+3:0] t;
        mac_t r;
        t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{MagWidth{1'b0}}, d};
        if (t > {4'b0000, max}) begin
            r.sat   = 1'b1;
            r.value = max;
        end else begin
            r.sat   = 1'b0;
            r.value = t[MagWidth-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/json_number_token_parser.sv
// A result is registered when the byte ending the number is accepted.
// One byte per cycle while s_tready is high; the digit update is a shift-add by ten.
// A two-entry output (result register plus skid register) lets input continue under stall.
// s_tready drops only while both output entries hold a result.
// Reset (aresetn low, synchronous) returns to the start phase, clears all accumulators
// and empties both output entries.
module json_number_token_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [jntp_pkg::TextWidth-1:0]      s_tdata,  // text_byte[7:0]
    input  logic                                s_tlast,  // end_of_text
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // is_negative[0], whole_part[63:1], fraction_part[126:64], fraction_digits[134:127],
    // exponent_value[166:135], overflowed[167], stop_byte_used[168], zero fill[175:169]
    output logic [jntp_pkg::OutDataWidth-1:0]   m_tdata,
    output logic                                m_tuser   // number_ok
);
    import jntp_pkg::*;

    logic [3:0]             phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [MagWidth-1:0]    whole_reg, whole_next;
    logic [MagWidth-1:0]    frac_reg, frac_next;
    logic [CountWidth-1:0]  count_reg, count_next;
    logic [ExpMagWidth-1:0] exp_reg, exp_next;
    logic                   exp_neg_reg, exp_neg_next;
    logic                   sat_reg, sat_next;

    result_t m_res_reg, m_res_next;
    logic    m_valid_reg, m_valid_next;
    result_t skid_res_reg, skid_res_next;
    logic    skid_valid_reg, skid_valid_next;

    logic [TextWidth-1:0] b;
    logic       digit, expmark, term;
    logic [3:0] d;
    logic       emit, ok, used, bad_phase;
    logic [3:0] nxt;
    logic       accept, m_fire, complete;
    mac_t       whole_mac, frac_mac, exp_mac;
    logic signed [ExpWidth-1:0] exp_signed;
    result_t    res;

    assign b       = s_tdata;
    assign digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    assign d       = digit ? b[3:0] : 4'd0;
    assign expmark = (b == CH_E_LOW) || (b == CH_E_UP);
    assign term    = (b == CH_COMMA) || (b == CH_RBRACK) || (b == CH_RBRACE);

    assign whole_mac = mac_sat(whole_reg, d, MagMax);
    assign frac_mac  = mac_sat(frac_reg, d, MagMax);
    assign exp_mac   = mac_sat({{(MagWidth-ExpMagWidth){1'b0}}, exp_reg}, d, ExpMax);

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_fire   = m_valid_reg && m_tready;

    always_comb begin
        neg_next     = neg_reg;
        whole_next   = whole_reg;
        frac_next    = frac_reg;
        count_next   = count_reg;
        exp_next     = exp_reg;
        exp_neg_next = exp_neg_reg;
        sat_next     = sat_reg;
        nxt          = phase_reg;
        emit         = 1'b0;
        ok           = 1'b0;
        used         = 1'b0;
        bad_phase    = 1'b0;
        case (phase_reg)
            PH_START, PH_SIGN: begin
                if (phase_reg == PH_START && b == CH_MINUS) begin
                    neg_next = 1'b1;
                    nxt      = PH_SIGN;
                end else if (digit) begin
                    whole_next = {{(MagWidth-4){1'b0}}, d};
                    nxt        = (d == 4'd0) ? PH_ZERO : PH_WHOLE;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_ZERO, PH_WHOLE: begin
                if (digit && phase_reg == PH_WHOLE) begin
                    whole_next = whole_mac.value;
                    sat_next   = sat_reg | whole_mac.sat;
                    nxt        = PH_WHOLE;
                end else if (b == CH_DOT) begin
                    nxt = PH_DOT;
                end else if (expmark) begin
                    nxt = PH_EXP;
                end else begin
                    emit = 1'b1;
                    ok   = term;
                end
            end
            PH_DOT, PH_FRAC: begin
                if (digit) begin
                    frac_next = frac_mac.value;
                    if (count_reg == CountMax) begin
                        sat_next = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                        sat_next   = sat_reg | frac_mac.sat;
                    end
                    if (frac_mac.sat) begin
                        sat_next = 1'b1;
                    end
                    nxt = PH_FRAC;
                end else if (expmark) begin
                    nxt = PH_EXP;
                end else begin
                    emit = 1'b1;
                    ok   = term;
                end
            end
            PH_EXP, PH_EXPSIGN: begin
                if (phase_reg == PH_EXP && b == CH_MINUS) begin
                    exp_neg_next = 1'b1;
                    nxt          = PH_EXPSIGN;
                end else if (phase_reg == PH_EXP && b == CH_PLUS) begin
                    nxt = PH_EXPSIGN;
                end else if (digit) begin
                    exp_next = {{(ExpMagWidth-4){1'b0}}, d};
                    nxt      = PH_EXPDIG;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_EXPDIG: begin
                if (digit) begin
                    exp_next = exp_mac.value[ExpMagWidth-1:0];
                    sat_next = sat_reg | exp_mac.sat;
                    nxt      = PH_EXPDIG;
                end else begin
                    emit = 1'b1;
                    ok   = 1'b1;
                end
            end
            default: begin
                bad_phase = 1'b1;
            end
        endcase

        complete = (nxt == PH_ZERO) || (nxt == PH_WHOLE) ||
                   (nxt == PH_FRAC) || (nxt == PH_EXPDIG);
        if (!emit && !bad_phase && s_tlast) begin
            emit = 1'b1;
            used = 1'b1;
            ok   = complete;
        end

        if (emit || bad_phase) begin
            phase_next = PH_START;
        end else begin
            phase_next = nxt;
        end
    end

    assign exp_signed = exp_neg_next ? -$signed({1'b0, exp_next}) : $signed({1'b0, exp_next});

    always_comb begin
        res.number_ok       = ok;
        res.is_negative     = ok & neg_next;
        res.whole_part      = ok ? whole_next : '0;
        res.fraction_part   = ok ? frac_next : '0;
        res.fraction_digits = ok ? count_next : '0;
        res.exponent_value  = ok ? exp_signed : '0;
        res.overflowed      = ok & sat_next;
        res.stop_byte_used  = used;
    end

    always_comb begin
        m_res_next      = m_res_reg;
        m_valid_next    = m_valid_reg;
        skid_res_next   = skid_res_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (m_fire) begin
                m_res_next      = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end else begin
            if (m_fire) begin
                m_valid_next = 1'b0;
            end
            if (accept && emit) begin
                if (!m_valid_reg || m_fire) begin
                    m_res_next   = res;
                    m_valid_next = 1'b1;
                end else begin
                    skid_res_next   = res;
                    skid_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            neg_reg        <= 1'b0;
            whole_reg      <= '0;
            frac_reg       <= '0;
            count_reg      <= '0;
            exp_reg        <= '0;
            exp_neg_reg    <= 1'b0;
            sat_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                if (emit || bad_phase) begin
                    neg_reg     <= 1'b0;
                    whole_reg   <= '0;
                    frac_reg    <= '0;
                    count_reg   <= '0;
                    exp_reg     <= '0;
                    exp_neg_reg <= 1'b0;
                    sat_reg     <= 1'b0;
                end else begin
                    neg_reg     <= neg_next;
                    whole_reg   <= whole_next;
                    frac_reg    <= frac_next;
                    count_reg   <= count_next;
                    exp_reg     <= exp_next;
                    exp_neg_reg <= exp_neg_next;
                    sat_reg     <= sat_next;
                end
            end
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg    <= m_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.number_ok;
    assign m_tdata  = {{(OutDataWidth-$bits(result_t)+1){1'b0}},
                       m_res_reg[$bits(result_t)-1:1]};

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held while output register empty");

    a_error_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_res_reg.number_ok) |-> (m_tdata[167:0] == 168'd0))
        else $error("error result carries nonzero payload");

    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_EXPDIG)
        else $error("parse phase out of range");

    a_emit_returns_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit) |=> (phase_reg == PH_START))
        else $error("phase not back at start after a result");
`endif

endmodule
